// ===== rtl/core/ecrf_pkg.sv =====
package ecrf_pkg;

  // Register file geometry
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned VEC_W      = 10;

  // Receive queue depth default
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Register numbers
  localparam logic [REG_IDX_W-1:0] REG_RXH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TXH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_VEC = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_CSR = 3'd7;
  // Registers below this one read back station address bytes
  localparam logic [REG_IDX_W-1:0] REG_SA_END = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SA_LAST = 3'd5;

  // CSR bit positions
  localparam int unsigned CSR_RE   = 0;   // receiver enable
  localparam int unsigned CSR_XL   = 4;   // transmit list invalid
  localparam int unsigned CSR_RL   = 5;   // receive list invalid
  localparam int unsigned CSR_IE   = 6;   // interrupt enable
  localparam int unsigned CSR_XI   = 7;   // transmit interrupt
  localparam int unsigned CSR_WIRE = 8;   // to wire, loopback when clear
  localparam int unsigned CSR_RI   = 15;  // receive interrupt

  // Masks
  localparam logic [WORD_W-1:0] CSR_WR_CLR   = 16'h8082;
  localparam logic [WORD_W-1:0] CSR_RO       = 16'h7834;
  localparam logic [WORD_W-1:0] CSR_WR_ZERO  = 16'h0800;
  localparam logic [WORD_W-1:0] CSR_RD_SET   = 16'h3000;
  localparam logic [WORD_W-1:0] VEC_WR_MASK  = 16'h07fd;
  localparam logic [WORD_W-1:0] VEC_OUT_MASK = 16'h03fc;
  localparam logic [WORD_W-1:0] BYTE_MASK    = 16'h00ff;

  // Reset values
  localparam logic [WORD_W-1:0] CSR_RESET = 16'h1031;
  localparam logic [WORD_W-1:0] VEC_RESET = 16'h01fc;

  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 11'd14;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_FRAME   = 3'd2,
    KIND_RX_DONE = 3'd3,
    KIND_TX_DONE = 3'd4
  } kind_e;

  typedef logic [NUM_REGS-1:0][WORD_W-1:0] regfile_t;

  typedef struct packed {
    kind_e                kind;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 byte_access;
    logic                 high_byte;
    logic [WORD_W-1:0]    write_data;
    logic [MAC_W-1:0]     dest_address;
    logic [LEN_W-1:0]     frame_length;
    logic                 completed;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              frame_accepted;
    logic              frame_dropped;
    logic              start_transmit;
    logic              send_to_wire;
    logic              irq_request;
    logic [VEC_W-1:0]  irq_vector;
    logic              rx_list_ready;
  } result_t;

endpackage

// ===== rtl/core/ecrf_exec.sv =====
module ecrf_exec import ecrf_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF,
  parameter int unsigned CntW       = $clog2(QueueDepth + 1)
) (
  input  item_t            item_i,
  input  logic [MAC_W-1:0] station_i,
  input  regfile_t         regs_i,
  input  logic [CntW-1:0]  cnt_i,
  output regfile_t         regs_o,
  output logic [CntW-1:0]  cnt_o,
  output result_t          res_o
);

  logic [WORD_W-1:0]    csr;
  logic [WORD_W-1:0]    old_word;
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    wr_word;
  logic [WORD_W-1:0]    csr_wr;
  logic [REG_IDX_W-1:0] sa_byte;
  logic                 addr_match;
  logic                 q_space;
  logic                 q_busy;

  assign csr      = regs_i[REG_CSR];
  assign old_word = regs_i[item_i.reg_index];
  assign q_space  = cnt_i < CntW'(QueueDepth);
  assign q_busy   = cnt_i != '0;

  // Own or broadcast destination
  assign addr_match = (item_i.dest_address == station_i) || (&item_i.dest_address);

  // Bus read word: station byte, stored word, or CSR with forced bits
  assign sa_byte = REG_SA_LAST - item_i.reg_index;
  always_comb begin
    rd_word = old_word;
    if (item_i.reg_index < REG_SA_END) begin
      rd_word = {8'h00, station_i[{sa_byte, 3'b000} +: 8]};
    end
    if (item_i.reg_index == REG_CSR) begin
      rd_word = old_word | CSR_RD_SET;
    end
  end

  // Byte writes merge into the stored word
  always_comb begin
    wr_word = item_i.write_data;
    if (item_i.byte_access) begin
      if (item_i.high_byte) begin
        wr_word = {item_i.write_data[7:0], old_word[7:0]};
      end else begin
        wr_word = {old_word[15:8], item_i.write_data[7:0]};
      end
    end
  end

  // CSR write: keep read-only bits, clear write-clear and write-zero bits, RI from queue
  always_comb begin
    csr_wr = ((wr_word & ~CSR_WR_CLR) & ~CSR_RO) | (old_word & CSR_RO);
    csr_wr = csr_wr & ~CSR_WR_ZERO;
    if (q_busy) begin
      csr_wr[CSR_RI] = 1'b1;
    end
  end

  // Item execution
  always_comb begin
    regs_o = regs_i;
    cnt_o  = cnt_i;
    res_o  = '0;
    case (item_i.kind)
      KIND_READ: begin
        if (item_i.byte_access) begin
          res_o.read_data = item_i.high_byte ? {8'h00, rd_word[15:8]}
                                             : (rd_word & BYTE_MASK);
        end else begin
          res_o.read_data = rd_word;
        end
      end
      KIND_WRITE: begin
        regs_o[item_i.reg_index] = wr_word;
        if (item_i.reg_index == REG_CSR) begin
          regs_o[REG_CSR] = csr_wr;
        end else if (item_i.reg_index == REG_RXH) begin
          regs_o[REG_CSR][CSR_RL] = 1'b0;
        end else if (item_i.reg_index == REG_TXH) begin
          regs_o[REG_CSR][CSR_XL] = 1'b0;
          res_o.start_transmit    = 1'b1;
        end else if (item_i.reg_index == REG_VEC) begin
          regs_o[REG_VEC] = wr_word & VEC_WR_MASK;
        end
      end
      KIND_FRAME: begin
        if (item_i.frame_length >= MIN_FRAME_LEN && addr_match) begin
          if (csr[CSR_RE] && q_space) begin
            res_o.frame_accepted = 1'b1;
            cnt_o                = cnt_i + 1'b1;
          end else begin
            res_o.frame_dropped = 1'b1;
          end
        end
      end
      KIND_RX_DONE: begin
        if (!csr[CSR_RL] && q_busy) begin
          cnt_o = cnt_i - 1'b1;
          if (item_i.completed) begin
            regs_o[REG_CSR][CSR_RI] = 1'b1;
            res_o.irq_request       = csr[CSR_IE];
          end
          regs_o[REG_CSR][CSR_RL] = 1'b1;
        end
      end
      KIND_TX_DONE: begin
        if (!csr[CSR_XL]) begin
          if (item_i.completed) begin
            if (item_i.frame_length != '0) begin
              if (csr[CSR_WIRE]) begin
                res_o.send_to_wire = 1'b1;
              end else if (q_space) begin
                res_o.frame_accepted = 1'b1;
                cnt_o                = cnt_i + 1'b1;
              end else begin
                res_o.frame_dropped = 1'b1;
              end
            end
            regs_o[REG_CSR][CSR_XI] = 1'b1;
            res_o.irq_request       = csr[CSR_IE];
          end
          regs_o[REG_CSR][CSR_XL] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // Status after the item
    res_o.irq_vector    = VEC_W'(regs_o[REG_VEC] & VEC_OUT_MASK);
    res_o.rx_list_ready = !regs_o[REG_CSR][CSR_RL];
  end

endmodule

// ===== rtl/core/ethernet_controller_csr_rx_filter.sv =====
// Channel  | handshake                    | payload
// ---------+------------------------------+----------------------------------------
// in       | in_valid_i / in_stall_o      | kind, reg_index, byte/high, data, addr, len, completed
// out      | out_valid_o / out_stall_i    | read_data, frame flags, irq, vector, list
// cfg      | cfg_we_i                     | cfg_wdata_i (station address)
//
// One word per cycle sustained while the output is not stalled; an accepted word
// goes into the input register, then executes into the result register.
// Register file and queue count update as a word moves into the result register.
// A stalled output holds its word; the input register still takes one more.
// Reset is asynchronous, active low; it clears the valid flags, queue count and
// station address and loads the register file reset values.
module ethernet_controller_csr_rx_filter import ecrf_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [MAC_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           kind_i,
  input  logic [REG_IDX_W-1:0] reg_index_i,
  input  logic                 byte_access_i,
  input  logic                 high_byte_i,
  input  logic [WORD_W-1:0]    write_data_i,
  input  logic [MAC_W-1:0]     dest_address_i,
  input  logic [LEN_W-1:0]     frame_length_i,
  input  logic                 completed_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [WORD_W-1:0]    read_data_o,
  output logic                 frame_accepted_o,
  output logic                 frame_dropped_o,
  output logic                 start_transmit_o,
  output logic                 send_to_wire_o,
  output logic                 irq_request_o,
  output logic [VEC_W-1:0]     irq_vector_o,
  output logic                 rx_list_ready_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // Register file reset image: CSR on top, vector below it, the rest zero
  localparam regfile_t RegsReset = {CSR_RESET, VEC_RESET, {(NUM_REGS - 2) * WORD_W{1'b0}}};

  logic             in_valid_q;
  item_t            in_q;
  logic             out_valid_q;
  result_t          out_q;
  logic [MAC_W-1:0] station_q;
  regfile_t         regs_q;
  regfile_t         regs_d;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_d;
  result_t          res_d;
  logic             in_take;
  logic             advance;
  logic             out_free;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.kind         <= kind_e'(kind_i);
      in_q.reg_index    <= reg_index_i;
      in_q.byte_access  <= byte_access_i;
      in_q.high_byte    <= high_byte_i;
      in_q.write_data   <= write_data_i;
      in_q.dest_address <= dest_address_i;
      in_q.frame_length <= frame_length_i;
      in_q.completed    <= completed_i;
    end
  end

  // Execute
  ecrf_exec #(
    .QueueDepth (QueueDepth),
    .CntW       (CntW)
  ) u_exec (
    .item_i    (in_q),
    .station_i (station_q),
    .regs_i    (regs_q),
    .cnt_i     (cnt_q),
    .regs_o    (regs_d),
    .cnt_o     (cnt_d),
    .res_o     (res_d)
  );

  // Station address, register file and queue count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_q <= '0;
      regs_q    <= RegsReset;
      cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        station_q <= cfg_wdata_i;
      end
      if (advance) begin
        regs_q <= regs_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = out_q.read_data;
  assign frame_accepted_o = out_q.frame_accepted;
  assign frame_dropped_o  = out_q.frame_dropped;
  assign start_transmit_o = out_q.start_transmit;
  assign send_to_wire_o   = out_q.send_to_wire;
  assign irq_request_o    = out_q.irq_request;
  assign irq_vector_o     = out_q.irq_vector;
  assign rx_list_ready_o  = out_q.rx_list_ready;

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("receive queue count above depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1) ||
    (cnt_q == $past(cnt_q) - 1'b1))
    else $error("receive queue count moved by more than one");

  a_acc_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_accepted_o && frame_dropped_o))
    else $error("frame both accepted and dropped");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input not stalled with both stages full");

endmodule

// ===== bench/ethernet_controller_csr_rx_filter_tb.sv =====
module ethernet_controller_csr_rx_filter_tb;
  import ecrf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = QUEUE_DEPTH_DEF;
  // Kind codes the block does not decode
  localparam logic [2:0] KIND_SPARE_MIN = 3'd5;
  localparam logic [2:0] KIND_SPARE_MAX = 3'd7;
  localparam logic [MAC_W-1:0] BCAST_MAC = '1;
  localparam int unsigned HOLD_CYCLES = 100;

  // One input word as driven on the ports; kind is kept raw so spare codes can be sent
  typedef struct packed {
    logic [2:0]           kind;
    logic [REG_IDX_W-1:0] reg_index;
    logic                 byte_access;
    logic                 high_byte;
    logic [WORD_W-1:0]    write_data;
    logic [MAC_W-1:0]     dest_address;
    logic [LEN_W-1:0]     frame_length;
    logic                 completed;
  } word_t;

  typedef struct {
    word_t   w;
    bit      typed;
    result_t want;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [MAC_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [2:0]           kind_i;
  logic [REG_IDX_W-1:0] reg_index_i;
  logic                 byte_access_i;
  logic                 high_byte_i;
  logic [WORD_W-1:0]    write_data_i;
  logic [MAC_W-1:0]     dest_address_i;
  logic [LEN_W-1:0]     frame_length_i;
  logic                 completed_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [WORD_W-1:0]    read_data_o;
  logic                 frame_accepted_o;
  logic                 frame_dropped_o;
  logic                 start_transmit_o;
  logic                 send_to_wire_o;
  logic                 irq_request_o;
  logic [VEC_W-1:0]     irq_vector_o;
  logic                 rx_list_ready_o;

  ethernet_controller_csr_rx_filter #(
    .QueueDepth(QDEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .reg_index_i     (reg_index_i),
    .byte_access_i   (byte_access_i),
    .high_byte_i     (high_byte_i),
    .write_data_i    (write_data_i),
    .dest_address_i  (dest_address_i),
    .frame_length_i  (frame_length_i),
    .completed_i     (completed_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .frame_accepted_o(frame_accepted_o),
    .frame_dropped_o (frame_dropped_o),
    .start_transmit_o(start_transmit_o),
    .send_to_wire_o  (send_to_wire_o),
    .irq_request_o   (irq_request_o),
    .irq_vector_o    (irq_vector_o),
    .rx_list_ready_o (rx_list_ready_o)
  );

  // Shadow of the register file, receive queue fill and station address
  logic [WORD_W-1:0] shadow_regs [NUM_REGS];
  int unsigned       rx_fill;
  logic [MAC_W-1:0]  own_mac;

  result_t expected_status [$];
  word_t   scenario_words [$];
  row_t    plan [$];

  int  errs;
  int  words_checked;
  int  n_queued, n_dropped, n_irq, n_start, n_wire, n_settings;
  bit  idle_on;
  bit  hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  // Reserve one receive queue slot if there is room
  function automatic bit take_slot();
    if (rx_fill < QDEPTH) begin
      rx_fill++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Status word the block should return for w; updates the shadow state
  function automatic result_t compute_status(input word_t w);
    result_t           res;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] old;
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] csr;
    int unsigned       ri;
    res = '0;
    ri  = 32'(w.reg_index);
    case (w.kind)
      KIND_READ: begin
        v = shadow_regs[ri];
        if (ri <= REG_SA_LAST) v = {8'h00, own_mac[8*(5-ri) +: 8]};
        if (w.reg_index == REG_CSR) v = v | CSR_RD_SET;
        if (w.byte_access) res.read_data = w.high_byte ? (v >> 8) : (v & BYTE_MASK);
        else res.read_data = v;
      end
      KIND_WRITE: begin
        v = w.write_data;
        if (w.byte_access) begin
          if (w.high_byte) v = {w.write_data[7:0], shadow_regs[ri][7:0]};
          else v = {shadow_regs[ri][15:8], w.write_data[7:0]};
        end
        old = shadow_regs[ri];
        shadow_regs[ri] = v;
        if (w.reg_index == REG_CSR) begin
          // status bits cleared, read-only bits kept, RI follows the queue
          n = v & ~CSR_WR_CLR;
          n = (n & ~CSR_RO) | (old & CSR_RO);
          n = n & ~CSR_WR_ZERO;
          if (rx_fill != 0) n[CSR_RI] = 1'b1;
          shadow_regs[REG_CSR] = n;
        end else if (w.reg_index == REG_RXH) begin
          shadow_regs[REG_CSR][CSR_RL] = 1'b0;
        end else if (w.reg_index == REG_TXH) begin
          shadow_regs[REG_CSR][CSR_XL] = 1'b0;
          res.start_transmit = 1'b1;
        end else if (w.reg_index == REG_VEC) begin
          shadow_regs[REG_VEC] = shadow_regs[REG_VEC] & VEC_WR_MASK;
        end
      end
      KIND_FRAME: begin
        // short or foreign frames are ignored
        if (w.frame_length >= MIN_FRAME_LEN &&
            (w.dest_address == own_mac || w.dest_address == BCAST_MAC)) begin
          if (shadow_regs[REG_CSR][CSR_RE]) begin
            res.frame_accepted = take_slot();
            res.frame_dropped  = !res.frame_accepted;
          end else begin
            res.frame_dropped = 1'b1;
          end
        end
      end
      KIND_RX_DONE: begin
        if (!shadow_regs[REG_CSR][CSR_RL] && rx_fill != 0) begin
          rx_fill--;
          if (w.completed) begin
            shadow_regs[REG_CSR][CSR_RI] = 1'b1;
            if (shadow_regs[REG_CSR][CSR_IE]) res.irq_request = 1'b1;
          end
          shadow_regs[REG_CSR][CSR_RL] = 1'b1;
        end
      end
      KIND_TX_DONE: begin
        csr = shadow_regs[REG_CSR];
        if (!csr[CSR_XL]) begin
          if (w.completed) begin
            // a zero-length transmit neither goes out nor loops back
            if (w.frame_length != 0) begin
              if (csr[CSR_WIRE]) begin
                res.send_to_wire = 1'b1;
              end else begin
                res.frame_accepted = take_slot();
                res.frame_dropped  = !res.frame_accepted;
              end
            end
            shadow_regs[REG_CSR][CSR_XI] = 1'b1;
            if (shadow_regs[REG_CSR][CSR_IE]) res.irq_request = 1'b1;
          end
          shadow_regs[REG_CSR][CSR_XL] = 1'b1;
        end
      end
      default: ;
    endcase
    res.irq_vector    = shadow_regs[REG_VEC][VEC_W-1:0] & VEC_OUT_MASK[VEC_W-1:0];
    res.rx_list_ready = !shadow_regs[REG_CSR][CSR_RL];
    return res;
  endfunction

  function automatic word_t mk(input logic [2:0] kind, input logic [REG_IDX_W-1:0] idx,
                               input logic byte_acc, input logic hi,
                               input logic [WORD_W-1:0] data, input logic [MAC_W-1:0] dest,
                               input logic [LEN_W-1:0] len, input logic done);
    word_t w;
    w.kind         = kind;
    w.reg_index    = idx;
    w.byte_access  = byte_acc;
    w.high_byte    = hi;
    w.write_data   = data;
    w.dest_address = dest;
    w.frame_length = len;
    w.completed    = done;
    return w;
  endfunction

  function automatic row_t row(input word_t w, input bit typed = 1'b0,
                               input result_t want = '0);
    row_t r;
    r.w     = w;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  // Expected status for rows where only data, vector and list ready are live
  function automatic result_t plain(input logic [WORD_W-1:0] rd, input logic [VEC_W-1:0] vec,
                                    input logic rlr);
    result_t r;
    r = '0;
    r.read_data     = rd;
    r.irq_vector    = vec;
    r.rx_list_ready = rlr;
    return r;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] r64;
    r64 = {$urandom(), $urandom()};
    return r64[MAC_W-1:0];
  endfunction

  // Destination: mostly own or broadcast, some near misses and noise
  function automatic logic [MAC_W-1:0] pick_dest();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 4) return own_mac;
    if (p < 7) return BCAST_MAC;
    if (p < 8) return own_mac ^ (48'd1 << $urandom_range(0, MAC_W - 1));
    return rand_mac();
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int unsigned p;
    p = $urandom_range(0, 9);
    if (p < 8) return LEN_W'($urandom_range(MIN_FRAME_LEN, 1514));
    if (p < 9) return LEN_W'($urandom_range(0, MIN_FRAME_LEN - 1));
    return LEN_W'($urandom_range(1515, 2047));
  endfunction

  function automatic word_t rand_word();
    word_t       w;
    int unsigned p;
    w = mk(KIND_READ, REG_IDX_W'($urandom_range(0, NUM_REGS - 1)), 1'($urandom()),
           1'($urandom()), WORD_W'($urandom()), pick_dest(), pick_len(), 1'($urandom()));
    p = $urandom_range(0, 99);
    if (p < 20)      w.kind = KIND_READ;
    else if (p < 40) w.kind = KIND_WRITE;
    else if (p < 65) w.kind = KIND_FRAME;
    else if (p < 78) w.kind = KIND_RX_DONE;
    else if (p < 93) w.kind = KIND_TX_DONE;
    else             w.kind = 3'($urandom_range(KIND_SPARE_MIN, KIND_SPARE_MAX));
    return w;
  endfunction

  // Queue a short scenario: mostly well-formed sequences with random content
  task automatic queue_scenario();
    word_t       w;
    int unsigned p;
    int unsigned k;
    p = $urandom_range(0, 99);
    if (p < 35) begin
      scenario_words.push_back(rand_word());
    end else if (p < 55) begin
      // arm the receive list, then a receive completion
      w = rand_word();
      w.kind = KIND_WRITE;
      w.reg_index = REG_RXH;
      scenario_words.push_back(w);
      w = rand_word();
      w.kind = KIND_RX_DONE;
      scenario_words.push_back(w);
    end else if (p < 70) begin
      // arm the transmit list, then a transmit completion
      w = rand_word();
      w.kind = KIND_WRITE;
      w.reg_index = REG_TXH;
      scenario_words.push_back(w);
      w = rand_word();
      w.kind = KIND_TX_DONE;
      w.completed = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) w.frame_length = '0;
      scenario_words.push_back(w);
    end else if (p < 82) begin
      // CSR rewrite, receiver mostly left enabled
      w = rand_word();
      w.kind = KIND_WRITE;
      w.reg_index = REG_CSR;
      if ($urandom_range(0, 3) != 0) w.write_data[CSR_RE] = 1'b1;
      scenario_words.push_back(w);
    end else begin
      // burst of matching frames
      k = $urandom_range(1, 6);
      repeat (k) begin
        w = rand_word();
        w.kind = KIND_FRAME;
        w.dest_address = ($urandom_range(0, 1) != 0) ? own_mac : BCAST_MAC;
        w.frame_length = LEN_W'($urandom_range(MIN_FRAME_LEN, 1514));
        scenario_words.push_back(w);
      end
    end
  endtask

  // Offer one word, after a random gap if idle_on is set, and hold it until taken
  task automatic send_word(input word_t w, input bit typed, input result_t want);
    int unsigned gap;
    result_t     res;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i         <= w.kind;
    reg_index_i    <= w.reg_index;
    byte_access_i  <= w.byte_access;
    high_byte_i    <= w.high_byte;
    write_data_i   <= w.write_data;
    dest_address_i <= w.dest_address;
    frame_length_i <= w.frame_length;
    completed_i    <= w.completed;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    res = compute_status(w);
    n_queued  += res.frame_accepted;
    n_dropped += res.frame_dropped;
    n_irq     += res.irq_request;
    n_start   += res.start_transmit;
    n_wire    += res.send_to_wire;
    expected_status.push_back(typed ? want : res);
  endtask

  // Station address change, only once the pipeline has drained
  task automatic load_mac(input logic [MAC_W-1:0] mac);
    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= mac;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    own_mac = mac;
    n_settings++;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned sent;
    word_t       w;
    sent = 0;
    while (sent < count) begin
      if (scenario_words.size() == 0) queue_scenario();
      w = scenario_words.pop_front();
      send_word(w, 1'b0, '0);
      sent++;
    end
  endtask

  task automatic cmp(input string field, input logic [WORD_W-1:0] want,
                     input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      errs++;
    end
  endtask

  // Result checker: every taken word against the oldest expectation
  result_t want_q;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_status.size() == 0) begin
        $error("status word with nothing expected");
        errs++;
      end else begin
        want_q = expected_status.pop_front();
        words_checked++;
        cmp("read_data", want_q.read_data, read_data_o);
        cmp("frame_accepted", 16'(want_q.frame_accepted), 16'(frame_accepted_o));
        cmp("frame_dropped", 16'(want_q.frame_dropped), 16'(frame_dropped_o));
        cmp("start_transmit", 16'(want_q.start_transmit), 16'(start_transmit_o));
        cmp("send_to_wire", 16'(want_q.send_to_wire), 16'(send_to_wire_o));
        cmp("irq_request", 16'(want_q.irq_request), 16'(irq_request_o));
        cmp("irq_vector", 16'(want_q.irq_vector), 16'(irq_vector_o));
        cmp("rx_list_ready", 16'(want_q.rx_list_ready), 16'(rx_list_ready_o));
      end
    end
  end

  // Receiver: random stall per word while idle_on is set, plus one long hold on request
  initial begin
    int unsigned n;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        n = idle_on ? $urandom_range(0, 8) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Stimulus
  initial begin
    logic [MAC_W-1:0] mac0;
    errs = 0;
    words_checked = 0;
    n_queued = 0;
    n_dropped = 0;
    n_irq = 0;
    n_start = 0;
    n_wire = 0;
    n_settings = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_valid_i     <= 1'b0;
    kind_i         <= '0;
    reg_index_i    <= '0;
    byte_access_i  <= 1'b0;
    high_byte_i    <= 1'b0;
    write_data_i   <= '0;
    dest_address_i <= '0;
    frame_length_i <= '0;
    completed_i    <= 1'b0;

    // shadow state as after reset
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    shadow_regs[REG_VEC] = VEC_RESET;
    shadow_regs[REG_CSR] = CSR_RESET;
    rx_fill = 0;
    own_mac = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    mac0 = 48'h02_11_22_33_44_55;
    load_mac(mac0);

    // Directed rows: reset readback, byte lanes, masks, filter and completion cases
    plan.push_back(row(mk(KIND_READ, REG_CSR, 0, 0, '0, '0, '0, 0), 1,
                       plain(16'h3031, 10'h1fc, 1'b0)));
    plan.push_back(row(mk(KIND_READ, REG_VEC, 0, 0, '0, '0, '0, 0), 1,
                       plain(16'h01fc, 10'h1fc, 1'b0)));
    plan.push_back(row(mk(KIND_READ, 3'd0, 1, 0, '0, '0, '0, 0), 1,
                       plain(16'h0002, 10'h1fc, 1'b0)));
    plan.push_back(row(mk(KIND_READ, REG_SA_LAST, 1, 1, '0, '0, '0, 0), 1,
                       plain(16'h0000, 10'h1fc, 1'b0)));
    plan.push_back(row(mk(KIND_READ, REG_CSR, 1, 1, '0, '0, '0, 0), 1,
                       plain(16'h0030, 10'h1fc, 1'b0)));
    plan.push_back(row(mk(KIND_WRITE, REG_VEC, 0, 0, 16'hffff, '0, '0, 0), 1,
                       plain(16'h0000, 10'h3fc, 1'b0)));
    plan.push_back(row(mk(KIND_WRITE, REG_VEC, 1, 1, 16'h00ff, '0, '0, 0)));
    plan.push_back(row(mk(KIND_WRITE, REG_CSR, 0, 0, 16'hffff, '0, '0, 0)));
    plan.push_back(row(mk(KIND_WRITE, REG_RXH, 0, 0, 16'h1234, '0, '0, 0)));
    plan.push_back(row(mk(KIND_WRITE, REG_TXH, 1, 1, 16'h00ab, '0, '0, 0)));
    plan.push_back(row(mk(KIND_FRAME, '0, 0, 0, '0, mac0, 11'd14, 0)));
    plan.push_back(row(mk(KIND_FRAME, '0, 0, 0, '0, BCAST_MAC, 11'd1514, 0)));
    plan.push_back(row(mk(KIND_FRAME, '0, 0, 0, '0, mac0, 11'd13, 0)));
    plan.push_back(row(mk(KIND_FRAME, '0, 0, 0, '0, mac0 ^ 48'd1, 11'd100, 0)));
    plan.push_back(row(mk(KIND_FRAME, '0, 0, 0, '0, BCAST_MAC, 11'd2047, 0)));
    plan.push_back(row(mk(KIND_RX_DONE, '0, 0, 0, '0, '0, '0, 1)));
    plan.push_back(row(mk(KIND_RX_DONE, '0, 0, 0, '0, '0, '0, 1)));
    plan.push_back(row(mk(KIND_WRITE, REG_RXH, 0, 0, 16'h0000, '0, '0, 0)));
    plan.push_back(row(mk(KIND_RX_DONE, '0, 0, 0, '0, '0, '0, 0)));
    plan.push_back(row(mk(KIND_TX_DONE, '0, 0, 0, '0, '0, 11'd100, 1)));
    plan.push_back(row(mk(KIND_TX_DONE, '0, 0, 0, '0, '0, 11'd50, 1)));
    plan.push_back(row(mk(KIND_WRITE, REG_CSR, 0, 0, 16'h0040, '0, '0, 0)));
    plan.push_back(row(mk(KIND_WRITE, REG_TXH, 0, 0, 16'hffff, '0, '0, 0)));
    plan.push_back(row(mk(KIND_TX_DONE, '0, 0, 0, '0, '0, 11'd60, 1)));
    plan.push_back(row(mk(KIND_FRAME, '0, 0, 0, '0, mac0, 11'd64, 0)));
    plan.push_back(row(mk(KIND_SPARE_MAX, 3'd7, 1, 1, 16'hffff, BCAST_MAC, 11'd2047, 1)));
    plan.push_back(row(mk(KIND_READ, REG_CSR, 0, 0, '0, '0, '0, 0)));
    foreach (plan[i]) send_word(plan[i].w, plan[i].typed, plan[i].want);

    // Random phases over several station addresses, extremes first
    load_mac('0);
    idle_on = 1'b0;
    run_random(405);

    load_mac(BCAST_MAC);
    idle_on = 1'b1;
    hold_req = 1'b1;
    run_random(405);

    load_mac(rand_mac());
    run_random(405);

    load_mac(48'hA5_5A_C3_3C_0F_F0);
    run_random(405);

    in_valid_i <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Checked %0d status words across %0d station address settings.",
             words_checked, n_settings);
    $display("Frames queued %0d, dropped %0d; interrupts %0d, transmit starts %0d, to wire %0d.",
             n_queued, n_dropped, n_irq, n_start, n_wire);
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
